/* design/gbf_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the ghost border fill block
// no dependencies

package gbf_pkg;

    localparam int P_IW = 12;
    localparam int P_CFG_DW = 7;

    typedef logic [P_IW-1:0] t_idx;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_FILL  = 2'd2,
        K_NOP   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_MARGIN = 2'd1,
        CFG_ROWS   = 2'd2,
        CFG_COLS   = 2'd3
    } t_cfg_idx;

    localparam logic [2:0] M_NONE     = 3'd0;
    localparam logic [2:0] M_ZERO     = 3'd1;
    localparam logic [2:0] M_CONST    = 3'd2;
    localparam logic [2:0] M_LINEAR   = 3'd3;
    localparam logic [2:0] M_MIRROR   = 3'd4;
    localparam logic [2:0] M_PERIODIC = 3'd5;
    localparam logic [2:0] M_PER_LIN  = 3'd6;

    typedef enum logic [2:0] {
        P_ZERO,
        P_CONST,
        P_LINEAR,
        P_MIRROR,
        P_PERIODIC
    } t_pass;

    typedef enum logic [1:0] {
        PH_ROWS,
        PH_COLS,
        PH_CORNER
    } t_phase;

    typedef struct packed {
        logic   wr_item;
        logic   rd_item;
        logic   rd_a;
        logic   rd_b;
        logic   wr_fill;
        logic   load_out;
        logic   out_fill;
        logic   out_ok;
        t_phase phase;
        logic   far;
        logic [1:0] q;
        t_idx   a;
        t_idx   k;
    } t_cmd;

    typedef struct packed {
        logic fill_active;
        logic geo_ok;
        logic corner_needed;
        logic near_end;
        logic far_end;
        logic k_last;
        logic out_free;
        t_idx far_start;
    } t_sts;

endpackage

/* design/gbf_in_if.sv */
`timescale 1ns / 1ps
// input channel carrying one write, read or fill transaction
// no dependencies

interface gbf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  row_index;
    logic [5:0]  col_index;
    logic signed [31:0] sample_in;

    modport source (output valid, kind, row_index, col_index, sample_in, input ready);
    modport sink (input valid, kind, row_index, col_index, sample_in, output ready);
endinterface

/* design/gbf_out_if.sv */
`timescale 1ns / 1ps
// result channel carrying read data and fill status
// no dependencies

interface gbf_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] sample_out;
    logic        fill_done;
    logic        geometry_error;

    modport source (output valid, sample_out, fill_done, geometry_error, input ready);
    modport sink (input valid, sample_out, fill_done, geometry_error, output ready);
endinterface

/* design/gbf_ctrl.sv */
`timescale 1ns / 1ps
// sequencer for item handling and the border fill walk
// depends on gbf_pkg

module gbf_ctrl import gbf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic [1:0] i_kind,
    output logic  o_ready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RESULT = 7'b0000010,
        S_STEP   = 7'b0000100,
        S_RDA    = 7'b0001000,
        S_RDB    = 7'b0010000,
        S_WR     = 7'b0100000,
        S_SPARE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_far, n_far;
    logic [1:0] r_q, n_q;
    t_idx   r_a, n_a;
    t_idx   r_k, n_k;
    logic   r_fill, n_fill;
    logic   r_ok, n_ok;
    logic   acc;

    assign o_ready = (r_state == S_IDLE);
    assign acc = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_far   = r_far;
        n_q     = r_q;
        n_a     = r_a;
        n_k     = r_k;
        n_fill  = r_fill;
        n_ok    = r_ok;
        o_cmd   = '0;
        o_cmd.phase = r_phase;
        o_cmd.far   = r_far;
        o_cmd.q     = r_q;
        o_cmd.a     = r_a;
        o_cmd.k     = r_k;
        o_cmd.out_fill = r_fill;
        o_cmd.out_ok   = r_ok;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (t_kind'(i_kind))
                        K_WRITE: o_cmd.wr_item = 1'b1;
                        K_READ: begin
                            o_cmd.rd_item = 1'b1;
                            n_fill  = 1'b0;
                            n_ok    = 1'b0;
                            n_state = S_RESULT;
                        end
                        K_FILL: begin
                            n_fill = 1'b1;
                            if (!i_sts.fill_active || !i_sts.geo_ok) begin
                                n_ok    = !i_sts.fill_active;
                                n_state = S_RESULT;
                            end else begin
                                n_phase = PH_ROWS;
                                n_far   = 1'b0;
                                n_a     = '0;
                                n_k     = '0;
                                n_q     = '0;
                                n_state = S_STEP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_STEP: begin
                if (r_phase == PH_CORNER) begin
                    if (i_sts.near_end) begin
                        n_ok    = 1'b1;
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_RDA;
                    end
                end else if (!r_far) begin
                    if (i_sts.near_end) begin
                        n_far = 1'b1;
                        n_a   = i_sts.far_start;
                    end else begin
                        n_state = S_RDA;
                    end
                end else if (i_sts.far_end) begin
                    n_far = 1'b0;
                    n_a   = '0;
                    if (!i_sts.k_last) begin
                        n_k = r_k + 1'b1;
                    end else if (r_phase == PH_ROWS) begin
                        n_phase = PH_COLS;
                        n_k     = '0;
                    end else if (i_sts.corner_needed) begin
                        n_phase = PH_CORNER;
                        n_q     = '0;
                    end else begin
                        n_ok    = 1'b1;
                        n_state = S_RESULT;
                    end
                end else begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr_fill = 1'b1;
                if (r_phase == PH_CORNER) begin
                    n_q = r_q + 1'b1;
                    if (r_q == 2'd3) n_a = r_a + 1'b1;
                end else begin
                    n_a = r_a + 1'b1;
                end
                n_state = S_STEP;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_ROWS;
            r_far   <= 1'b0;
            r_q     <= '0;
            r_a     <= '0;
            r_k     <= '0;
            r_fill  <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_far   <= n_far;
            r_q     <= n_q;
            r_a     <= n_a;
            r_k     <= n_k;
            r_fill  <= n_fill;
            r_ok    <= n_ok;
        end
    end

endmodule

/* design/gbf_datapath.sv */
`timescale 1ns / 1ps
// sample memory, configuration registers, index arithmetic and result register
// depends on gbf_pkg

module gbf_datapath import gbf_pkg::*; #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [P_CFG_DW-1:0] i_cfg_data,
    input  logic [5:0]  i_row_index,
    input  logic [5:0]  i_col_index,
    input  logic signed [31:0] i_sample_in,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic signed [31:0] o_sample_out,
    output logic        o_fill_done,
    output logic        o_geometry_error,
    input  t_cmd        i_cmd,
    output t_sts        o_sts
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (SAMPLE_BITS > 32) ? SAMPLE_BITS + 1 : 33;
    localparam int SW = SAMPLE_BITS;

    logic [2:0] r_mode;
    logic [4:0] r_margin;
    logic [6:0] r_rows;
    logic [6:0] r_cols;

    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] r_rdata;
    logic [SW-1:0] r_aval;
    logic          r_rd_zero;
    logic          r_ovalid;
    logic signed [31:0] r_osample;
    logic          r_odone;
    logic          r_oerr;

    t_idx m, n, w, need, len, across, e, anchor, second, far_start;
    t_idx src_r, src_c, b_r, b_c, dst_r, dst_c;
    t_pass pk, rk, ck;
    logic cols;
    logic item_in_range;
    logic [AW-1:0] item_addr, a_addr, b_addr, d_addr, raddr;
    logic we, re;
    logic [SW-1:0] wdata, item_w, fill_w, lin_w;
    logic signed [XW-1:0] sx, s_max, s_min, rx, o_max, o_min;
    logic signed [SW:0] dif, sum;
    logic signed [SW-1:0] dif_s;
    logic signed [31:0] rd_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_NONE;
            r_margin <= 5'd1;
            r_rows   <= 7'd64;
            r_cols   <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:   r_mode   <= i_cfg_data[2:0];
                CFG_MARGIN: r_margin <= i_cfg_data[4:0];
                CFG_ROWS:   r_rows   <= i_cfg_data;
                CFG_COLS:   r_cols   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        m = (P_IW'(r_rows) > P_IW'(MAX_ROWS)) ? P_IW'(MAX_ROWS) : P_IW'(r_rows);
        n = (P_IW'(r_cols) > P_IW'(MAX_COLS)) ? P_IW'(MAX_COLS) : P_IW'(r_cols);
        w = P_IW'(r_margin);
        rk = P_ZERO;
        ck = P_ZERO;
        need = w;
        case (r_mode)
            M_ZERO: begin rk = P_ZERO; ck = P_ZERO; need = w; end
            M_CONST: begin rk = P_CONST; ck = P_CONST; need = w + 1'b1; end
            M_LINEAR: begin rk = P_LINEAR; ck = P_LINEAR; need = (w << 1) + 1'b1; end
            M_MIRROR: begin rk = P_MIRROR; ck = P_MIRROR; need = (w << 1) + 1'b1; end
            M_PERIODIC: begin rk = P_PERIODIC; ck = P_PERIODIC; need = (w << 1) + 1'b1; end
            M_PER_LIN: begin rk = P_PERIODIC; ck = P_LINEAR; need = (w << 1) + 1'b1; end
            default: ;
        endcase

        cols   = (i_cmd.phase == PH_COLS);
        pk     = (i_cmd.phase == PH_CORNER) ? P_CONST : (cols ? ck : rk);
        len    = cols ? n : m;
        across = cols ? m : n;
        e      = len - 1'b1 - w;
        anchor = i_cmd.far ? e : w;
        far_start = (pk == P_PERIODIC) ? len - w - 1'b1 : len - w;
        if (pk == P_PERIODIC) begin
            second = i_cmd.far ? i_cmd.a + (w << 1) + 1'b1 - len
                               : len - 1'b1 - (w << 1) + i_cmd.a;
        end else begin
            second = (anchor << 1) - i_cmd.a;
        end

        if (i_cmd.phase == PH_CORNER) begin
            src_r = i_cmd.q[0] ? m - 1'b1 - w : w;
            src_c = i_cmd.q[1] ? n - 1'b1 - w : w;
            b_r   = src_r;
            b_c   = src_c;
            dst_r = i_cmd.q[0] ? m - 1'b1 - i_cmd.a : i_cmd.a;
            dst_c = i_cmd.q[1] ? n - 1'b1 - i_cmd.a : i_cmd.a;
        end else if (cols) begin
            src_r = i_cmd.k;  src_c = anchor;
            b_r   = i_cmd.k;  b_c   = second;
            dst_r = i_cmd.k;  dst_c = i_cmd.a;
        end else begin
            src_r = anchor;   src_c = i_cmd.k;
            b_r   = second;   b_c   = i_cmd.k;
            dst_r = i_cmd.a;  dst_c = i_cmd.k;
        end
    end

    assign item_in_range = (P_IW'(i_row_index) < P_IW'(MAX_ROWS))
                        && (P_IW'(i_col_index) < P_IW'(MAX_COLS));
    assign item_addr = AW'(AW'(i_row_index) * AW'(MAX_COLS) + AW'(i_col_index));
    assign a_addr = AW'(AW'(src_r) * AW'(MAX_COLS) + AW'(src_c));
    assign b_addr = AW'(AW'(b_r) * AW'(MAX_COLS) + AW'(b_c));
    assign d_addr = AW'(AW'(dst_r) * AW'(MAX_COLS) + AW'(dst_c));

    // write data saturation to the stored width
    always_comb begin
        s_max = XW'(signed'({1'b0, {(SW-1){1'b1}}}));
        s_min = ~s_max;
        sx = XW'(i_sample_in);
        if (sx > s_max) item_w = s_max[SW-1:0];
        else if (sx < s_min) item_w = s_min[SW-1:0];
        else item_w = sx[SW-1:0];
    end

    // 2a - b with saturation at each step
    always_comb begin
        dif = (SW+1)'(signed'(r_aval)) - (SW+1)'(signed'(r_rdata));
        if (dif[SW] != dif[SW-1]) dif_s = dif[SW] ? signed'({1'b1, {(SW-1){1'b0}}})
                                                  : signed'({1'b0, {(SW-1){1'b1}}});
        else dif_s = dif[SW-1:0];
        sum = (SW+1)'(signed'(r_aval)) + (SW+1)'(dif_s);
        if (sum[SW] != sum[SW-1]) lin_w = sum[SW] ? {1'b1, {(SW-1){1'b0}}}
                                                  : {1'b0, {(SW-1){1'b1}}};
        else lin_w = sum[SW-1:0];
    end

    always_comb begin
        case (pk)
            P_CONST: fill_w = r_aval;
            P_LINEAR: fill_w = lin_w;
            P_MIRROR, P_PERIODIC: fill_w = r_rdata;
            default: fill_w = '0;
        endcase
    end

    assign we    = (i_cmd.wr_item && item_in_range) || i_cmd.wr_fill;
    assign wdata = i_cmd.wr_fill ? fill_w : item_w;
    assign re    = i_cmd.rd_item || i_cmd.rd_a || i_cmd.rd_b;
    assign raddr = i_cmd.rd_item ? item_addr : (i_cmd.rd_a ? a_addr : b_addr);

    always_ff @(posedge i_clk) begin
        if (we) mem[i_cmd.wr_fill ? d_addr : item_addr] <= wdata;
        if (re) r_rdata <= mem[raddr];
        if (i_cmd.rd_item) r_rd_zero <= !item_in_range;
        if (i_cmd.rd_b) r_aval <= r_rdata;
    end

    // read data to the 32 bit result
    always_comb begin
        o_max = XW'(signed'({1'b0, {31{1'b1}}}));
        o_min = ~o_max;
        rx = XW'(signed'(r_rdata));
        if (r_rd_zero) rd_out = '0;
        else if (rx > o_max) rd_out = o_max[31:0];
        else if (rx < o_min) rd_out = o_min[31:0];
        else rd_out = rx[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_osample <= i_cmd.out_fill ? '0 : rd_out;
            r_odone   <= i_cmd.out_fill && i_cmd.out_ok;
            r_oerr    <= i_cmd.out_fill && !i_cmd.out_ok;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_sample_out     = r_osample;
    assign o_fill_done      = r_odone;
    assign o_geometry_error = r_oerr;

    always_comb begin
        o_sts.fill_active   = (r_mode != M_NONE) && (r_mode <= M_PER_LIN);
        o_sts.geo_ok        = (m != '0) && (n != '0) && (need <= m) && (need <= n);
        o_sts.corner_needed = (r_mode == M_CONST);
        o_sts.near_end      = (i_cmd.a >= w);
        o_sts.far_end       = (i_cmd.a >= len);
        o_sts.k_last        = (i_cmd.k == across - 1'b1);
        o_sts.out_free      = !r_ovalid || i_out_ready;
        o_sts.far_start     = far_start;
    end

endmodule

/* design/ghost_border_fill.sv */
`timescale 1ns / 1ps
// ghost border fill top level: a grid of Q16.16 samples with a border fill
// depends on gbf_pkg, gbf_in_if, gbf_out_if, gbf_ctrl, gbf_datapath
//
// Write and read transactions both go through the sample memory one access at a time; a read
// result waits in the output register while the next transaction is taken. A fill walks the
// border band one cell at a time with two memory reads and one write per cell; a periodic
// pass writes one more cell per line on the far side, and the constant mode adds a corner
// pass. The memory has no clear after reset; cells read before they are written return
// undefined data.

module ghost_border_fill import gbf_pkg::*; #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [P_CFG_DW-1:0] i_cfg_data,
    gbf_in_if.sink          i_item,
    gbf_out_if.source       o_result
);

    t_cmd cmd;
    t_sts sts;
    logic ready;

    assign i_item.ready = ready;

    gbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_item.valid),
        .i_kind  (i_item.kind),
        .o_ready (ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gbf_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_row_index      (i_item.row_index),
        .i_col_index      (i_item.col_index),
        .i_sample_in      (i_item.sample_in),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_sample_out     (o_result.sample_out),
        .o_fill_done      (o_result.fill_done),
        .o_geometry_error (o_result.geometry_error),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule
